// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check wrappers, clocked on clk; DSPT_CHECK is held off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every edge outside reset
`define DSPT_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check on every edge, reset included
`define DSPT_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: src/dspt_pkg.sv
// ----------------------------------------------------------------------------
// dspt_pkg
// shared types and constants of the depth sorted particle table
// ----------------------------------------------------------------------------
package dspt_pkg;

  // default table size
  localparam int DEPTH_DEFAULT = 1024;

  // width of a cell position on the control bus, enough for 4096 cells
  localparam int TAIL_W = 12;

  // one particle; depth and height are signed q8.8, speed unsigned q8.8
  typedef struct packed {
    logic [15:0] depth;
    logic [15:0] height;
    logic [15:0] speed;
    logic [31:0] payload;
  } entry_t;

  // broadcast control for the row of cells
  typedef struct packed {
    logic              shift;    // cells below tail take their neighbor
    logic              tail_wr;  // cell at tail takes the head result
    logic [TAIL_W-1:0] tail;     // position of the ring tail
  } cell_ctrl_t;

endpackage

// File: src/dspt_cell.sv
// ----------------------------------------------------------------------------
// dspt_cell
// one table slot; moves toward the head or takes the head result at the tail
// ----------------------------------------------------------------------------
module dspt_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  dspt_pkg::cell_ctrl_t ctrl,
  input  dspt_pkg::entry_t    nbr,
  input  dspt_pkg::entry_t    tail_data,
  output dspt_pkg::entry_t    q
);
  import dspt_pkg::*;

  localparam logic [TAIL_W-1:0] MY_IDX = TAIL_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      if (MY_IDX < ctrl.tail) begin
        q <= nbr;
      end else if ((MY_IDX == ctrl.tail) && ctrl.tail_wr) begin
        q <= tail_data;
      end
    end
  end

endmodule

// File: src/dspt_fall.sv
// ----------------------------------------------------------------------------
// dspt_fall
// fall distance floor(speed * ms / 1000), two register stages
// ----------------------------------------------------------------------------
module dspt_fall (
  input  logic        clk,
  input  logic [15:0] speed,
  input  logic [9:0]  ms,
  output logic [16:0] drop
);
  import dspt_pkg::*;

  // exact reciprocal of 1000 for products below 2^26
  localparam int          PW         = 26;
  localparam int          RW         = 28;
  localparam int          FALL_SHIFT = 37;
  localparam logic [RW-1:0] FALL_RECIP = 28'd137438954;

  logic [PW-1:0]    prod_ms;
  logic [PW+RW-1:0] prod_recip;

  assign prod_recip = {{RW{1'b0}}, prod_ms} * {{PW{1'b0}}, FALL_RECIP};

  always_ff @(posedge clk) begin
    prod_ms <= {10'b0, speed} * {16'b0, ms};
    drop    <= prod_recip[FALL_SHIFT +: 17];
  end

endmodule

// File: src/depth_sorted_particle_table.sv
// ----------------------------------------------------------------------------
// depth_sorted_particle_table
// particle table kept in descending depth order, with insert, frame and read
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with command and its operands; one
//   transaction per command. in_stall is high while a command is in work.
//   output channel: out_valid / out_stall, one result transaction per command,
//   held in an output register so the next command may be taken while a
//   result still waits for the receiver.
//   the table is a ring of cells; a command sweeps the live entries past
//   the head cell, one entry per step, and the head writes back at the tail.
//   a frame runs product, reciprocal and write back for each entry.
//   a refused insert or a read of an index that is not live skips the sweep;
//   a new command is taken only after the last one is done, and the sweep
//   length sets how long a command takes. reset empties the table and loads
//   capacity 1000 and kill level -3.0. a stalled result holds; a finished
//   command waits until the slot frees. configuration goes through the apb
//   port while the block is idle; the user is bound to that, the block does
//   not enforce it.
// ----------------------------------------------------------------------------
module depth_sorted_particle_table #(
  parameter int DEPTH = dspt_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  // command channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         command,
  input  logic signed [15:0] depth_in,
  input  logic signed [15:0] height_in,
  input  logic [15:0]        speed_in,
  input  logic [31:0]        payload_in,
  input  logic [9:0]         elapsed_ms,
  input  logic [9:0]         read_index,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               accepted,
  output logic [9:0]         position,
  output logic [10:0]        live_total,
  output logic [10:0]        removed_total,
  output logic               entry_valid,
  output logic signed [15:0] entry_depth,
  output logic signed [15:0] entry_height,
  output logic [15:0]        entry_speed,
  output logic [31:0]        entry_payload,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import dspt_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 11) ? CW : 11;

  // command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_FRAME  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;

  // register index, taken from byte address bit 2
  localparam logic REG_CAPACITY   = 1'b0;
  localparam logic REG_KILL_LEVEL = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_FRAME_P,
    S_FRAME_Q,
    S_FRAME_W,
    S_READ,
    S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic [10:0]        capacity;
  logic signed [15:0] kill_level;

  // table occupancy and sweep control
  logic [CW-1:0] live;
  logic [CW-1:0] k;        // entries seen by the head in this sweep
  logic [CW-1:0] w;        // survivors written back during a frame
  logic [IW-1:0] tail;     // ring tail position
  logic          placed;   // new entry already handed to the tail
  entry_t        hold;     // entry displaced by the insert

  // latched command operands
  entry_t        new_ent;
  logic [9:0]    ms_q;
  logic [9:0]    ridx;

  // staged result
  logic          res_accepted;
  logic [9:0]    res_pos;
  logic [10:0]   res_removed;
  logic          res_valid;
  entry_t        res_entry;

  // the cell row
  entry_t        cell_q [DEPTH];
  entry_t        head_ent;
  entry_t        tail_data;
  cell_ctrl_t    ctrl;

  // head logic
  logic [LW-1:0]      cap_ext;
  logic [LW-1:0]      eff_cap;
  logic [LW-1:0]      ins_limit;
  logic               ins_ok;
  logic               rd_ok;
  logic               ins_take_new;
  logic               keep;
  logic [16:0]        drop;
  logic signed [18:0] hsum;
  logic [15:0]        h_new;
  entry_t             frame_ent;
  logic [CW-1:0]      w_next;

  assign head_ent = cell_q[0];
  assign in_stall = (state != S_IDLE);
  assign pready   = 1'b1;

  // register readback
  always_comb begin
    case (paddr[2])
      REG_CAPACITY:   prdata = {21'b0, capacity};
      REG_KILL_LEVEL: prdata = {16'b0, kill_level};
      default:        prdata = '0;
    endcase
  end

  // insert refused once live reaches min(capacity, DEPTH) - 1
  assign cap_ext   = LW'(capacity);
  assign eff_cap   = (cap_ext < LW'(DEPTH)) ? cap_ext : LW'(DEPTH);
  assign ins_limit = (eff_cap == '0) ? '0 : eff_cap - LW'(1);
  assign ins_ok    = LW'(live) < ins_limit;
  assign rd_ok     = LW'(read_index) < LW'(live);

  // new entry goes before the first live entry of smaller depth
  assign ins_take_new = !placed &&
                        ((k == live) || ($signed(head_ent.depth) < $signed(new_ent.depth)));

  // fall update of the head entry, saturating at the most negative height
  dspt_fall u_fall (
    .clk   (clk),
    .speed (head_ent.speed),
    .ms    (ms_q),
    .drop  (drop)
  );

  assign keep   = !($signed(head_ent.height) < kill_level);
  assign hsum   = $signed({{3{head_ent.height[15]}}, head_ent.height}) -
                  $signed({2'b00, drop});
  assign h_new  = (hsum < -19'sd32768) ? 16'h8000 : hsum[15:0];
  assign w_next = keep ? w + CW'(1) : w;

  always_comb begin
    frame_ent        = head_ent;
    frame_ent.height = h_new;
  end

  // what the head hands to the ring tail
  always_comb begin
    case (state)
      S_INSERT: begin
        if (ins_take_new) begin
          tail_data = new_ent;
        end else if (placed) begin
          tail_data = hold;
        end else begin
          tail_data = head_ent;
        end
      end
      S_FRAME_W: tail_data = frame_ent;
      default:   tail_data = head_ent;
    endcase
  end

  always_comb begin
    ctrl.shift   = state inside {S_INSERT, S_READ, S_FRAME_W};
    ctrl.tail_wr = (state inside {S_INSERT, S_READ}) || ((state == S_FRAME_W) && keep);
    ctrl.tail    = TAIL_W'(tail);
  end

  // row of cells, each fed by its neighbor toward the tail
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t nbr;
    if (g == DEPTH - 1) begin : g_last
      assign nbr = tail_data;
    end else begin : g_mid
      assign nbr = cell_q[g+1];
    end
    dspt_cell #(
      .IDX (g)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .nbr       (nbr),
      .tail_data (tail_data),
      .q         (cell_q[g])
    );
  end

  // command sequencer and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live       <= '0;
      out_valid  <= 1'b0;
      capacity   <= 11'd1000;
      kill_level <= -16'sd768;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[2])
          REG_CAPACITY:   capacity   <= pwdata[10:0];
          REG_KILL_LEVEL: kill_level <= pwdata[15:0];
          default:        ;
        endcase
      end

      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            new_ent      <= '{depth: depth_in, height: height_in,
                              speed: speed_in, payload: payload_in};
            ms_q         <= elapsed_ms;
            ridx         <= read_index;
            k            <= '0;
            w            <= '0;
            placed       <= 1'b0;
            res_accepted <= 1'b0;
            res_pos      <= '0;
            res_removed  <= '0;
            res_valid    <= 1'b0;
            res_entry    <= '0;
            case (command)
              CMD_INSERT: begin
                if (ins_ok) begin
                  tail  <= IW'(live);
                  state <= S_INSERT;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_FRAME: begin
                if (live != '0) begin
                  tail  <= IW'(live - CW'(1));
                  state <= S_FRAME_P;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_READ: begin
                if (rd_ok) begin
                  tail  <= IW'(live - CW'(1));
                  state <= S_READ;
                end else begin
                  state <= S_DONE;
                end
              end
              default: state <= S_DONE;
            endcase
          end
        end

        // one entry per cycle, the sweep runs one step past the last live entry
        S_INSERT: begin
          k <= k + CW'(1);
          if (ins_take_new) begin
            hold    <= head_ent;
            placed  <= 1'b1;
            res_pos <= 10'(k);
          end else if (placed) begin
            hold <= head_ent;
          end
          if (k == live) begin
            live         <= live + CW'(1);
            res_accepted <= 1'b1;
            state        <= S_DONE;
          end
        end

        S_FRAME_P: state <= S_FRAME_Q;
        S_FRAME_Q: state <= S_FRAME_W;

        // survivors go to the tail, removed entries shrink the ring
        S_FRAME_W: begin
          k <= k + CW'(1);
          w <= w_next;
          if (!keep) begin
            tail <= tail - IW'(1);
          end
          if (k == live - CW'(1)) begin
            live        <= w_next;
            res_removed <= 11'(live - w_next);
            state       <= S_DONE;
          end else begin
            state <= S_FRAME_P;
          end
        end

        // full pass so every entry lands back in place
        S_READ: begin
          k <= k + CW'(1);
          if (LW'(k) == LW'(ridx)) begin
            res_valid <= 1'b1;
            res_entry <= head_ent;
          end
          if (k == live - CW'(1)) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            accepted      <= res_accepted;
            position      <= res_pos;
            live_total    <= 11'(live);
            removed_total <= res_removed;
            entry_valid   <= res_valid;
            entry_depth   <= res_entry.depth;
            entry_height  <= res_entry.height;
            entry_speed   <= res_entry.speed;
            entry_payload <= res_entry.payload;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"

  // occupancy moves only at the end of an insert or a frame
  `DSPT_CHECK(a_live_moves, (!$past(rst) && !$stable(live)) |-> $past(state == S_INSERT || state == S_FRAME_W), "live count changed outside insert or frame")
  // ring tail tracks unprocessed plus written back entries during a frame
  `DSPT_CHECK(a_frame_tail, (state == S_FRAME_P || state == S_FRAME_Q || state == S_FRAME_W) |-> ((LW'(tail) + LW'(1)) == (LW'(live) + LW'(w) - LW'(k))), "frame ring tail out of step")
  // survivors never outnumber entries seen
  `DSPT_CHECK(a_frame_kept, (state == S_FRAME_W) |-> (w <= k), "more survivors than entries seen")
  // an insert in work always leaves one free cell
  `DSPT_CHECK(a_insert_room, (state == S_INSERT) |-> (LW'(live) < (LW'(DEPTH) - LW'(1))), "insert started on a full table")

endmodule
